// File: src/psc_pkg.sv
// Shared types, constants and helpers for the pitch speech classifier.
// Holds the configuration and per-source state records, register codes
// and reset values. No dependencies.
`default_nettype none

package psc_pkg;

    // Field widths
    localparam int IDX_W      = 2;
    localparam int LAG_W      = 32;
    localparam int LIM_W      = 31;
    localparam int GAIN_W     = 17;
    localparam int SRC_CNT_W  = 7;

    // Configuration port geometry
    localparam int REG_IDX_W  = 3;
    localparam int PADDR_W    = REG_IDX_W + 2;
    localparam int PDATA_W    = 32;

    // Default number of tracked sources
    localparam int NUM_SOURCES_DEF = 4;

    // 1.0 in Q1.16 and the rounding bias of a Q16 shift
    localparam logic [GAIN_W-1:0] Q16_ONE   = 17'h10000;
    localparam logic [15:0]       HALF_LSB  = 16'h8000;

    // Register codes, in address order
    typedef enum logic [REG_IDX_W-1:0] {
        REG_LAG_MIN         = 3'd0,
        REG_LAG_MAX         = 3'd1,
        REG_CHANGE_LIMIT    = 3'd2,
        REG_CHANGE_GAIN     = 3'd3,
        REG_RATIO_GAIN      = 3'd4,
        REG_CHANGE_MIN      = 3'd5,
        REG_RATIO_THRESHOLD = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [LIM_W-1:0]  lag_min;
        logic [LIM_W-1:0]  lag_max;
        logic [LIM_W-1:0]  change_limit;
        logic [GAIN_W-1:0] change_gain;
        logic [GAIN_W-1:0] ratio_gain;
        logic [LIM_W-1:0]  change_min;
        logic [GAIN_W-1:0] ratio_threshold;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        lag_min:         31'd0,
        lag_max:         31'h7FFF_FFFF,
        change_limit:    31'd65536,
        change_gain:     17'd32768,
        ratio_gain:      17'd6554,
        change_min:      31'd0,
        ratio_threshold: 17'd32768
    };

    // Per-source state record kept in the state memory
    typedef struct packed {
        logic signed [LAG_W-1:0] last_lag;
        logic signed [LAG_W-1:0] last_change;
        logic signed [LAG_W-1:0] smoothed_change;
        logic [GAIN_W-1:0]       voicing_ratio;
        logic                    speech_latched;
    } t_state;

    // Limit a gain to 1.0
    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
        return (g > Q16_ONE) ? Q16_ONE : g;
    endfunction

    // Magnitude of a signed 32 bit value, exact for the most negative one
    function automatic logic [LAG_W-1:0] mag32(input logic signed [LAG_W-1:0] x);
        return x[LAG_W-1] ? (~x + 32'd1) : x;
    endfunction

endpackage

`default_nettype wire

// File: src/psc_cfg_regs.sv
// Configuration register bank of the pitch speech classifier, APB-style port.
// Depends on psc_pkg for the register codes, record type and reset values.
`default_nettype none

module psc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [psc_pkg::PADDR_W-1:0]  paddr,
    input  logic [psc_pkg::PDATA_W-1:0]  pwdata,
    output logic [psc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output psc_pkg::t_cfg                o_cfg
);
    import psc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    // Decode the word address
    assign reg_sel = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write the selected register in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_LAG_MIN:         r_cfg.lag_min         <= pwdata[LIM_W-1:0];
                REG_LAG_MAX:         r_cfg.lag_max         <= pwdata[LIM_W-1:0];
                REG_CHANGE_LIMIT:    r_cfg.change_limit    <= pwdata[LIM_W-1:0];
                REG_CHANGE_GAIN:     r_cfg.change_gain     <= pwdata[GAIN_W-1:0];
                REG_RATIO_GAIN:      r_cfg.ratio_gain      <= pwdata[GAIN_W-1:0];
                REG_CHANGE_MIN:      r_cfg.change_min      <= pwdata[LIM_W-1:0];
                REG_RATIO_THRESHOLD: r_cfg.ratio_threshold <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Return the selected register, zero beyond the list
    always_comb begin
        case (reg_sel)
            REG_LAG_MIN:         prdata = PDATA_W'(r_cfg.lag_min);
            REG_LAG_MAX:         prdata = PDATA_W'(r_cfg.lag_max);
            REG_CHANGE_LIMIT:    prdata = PDATA_W'(r_cfg.change_limit);
            REG_CHANGE_GAIN:     prdata = PDATA_W'(r_cfg.change_gain);
            REG_RATIO_GAIN:      prdata = PDATA_W'(r_cfg.ratio_gain);
            REG_CHANGE_MIN:      prdata = PDATA_W'(r_cfg.change_min);
            REG_RATIO_THRESHOLD: prdata = PDATA_W'(r_cfg.ratio_threshold);
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: src/psc_state_ram.sv
// Per-source state memory: one write port, one read port with registered data.
// Entries read as zero until first written. Depends on psc_pkg for t_state.
`default_nettype none

module psc_state_ram #(
    parameter int DEPTH  = psc_pkg::NUM_SOURCES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  psc_pkg::t_state    i_wr_data,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output psc_pkg::t_state    o_rd_data
);
    import psc_pkg::*;

    t_state           r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_state           r_rd_data;

    assign o_rd_data = r_rd_data;

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Read the old contents; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

endmodule

`default_nettype wire

// File: src/pitch_speech_classifier.sv
// Pitch speech classifier: per-source voicing tracker with latched speech flag.
// Each accepted input item passes through the stage 1, stage 2 and result registers.
// Throughput: 1 item per cycle while the result channel is not stalled; an item for the
// same source as the one just ahead waits in stage 1 until that item's state is written back.
// Reset (synchronous, active low): pipeline emptied, registers to defaults,
// all per-source state reads as zero.
`default_nettype none

module pitch_speech_classifier #(
    parameter int NUM_SOURCES = psc_pkg::NUM_SOURCES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psc_pkg::PADDR_W-1:0]         paddr,
    input  logic [psc_pkg::PDATA_W-1:0]         pwdata,
    output logic [psc_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [psc_pkg::IDX_W-1:0]           i_source_index,
    input  logic                                i_track_active,
    input  logic signed [psc_pkg::LAG_W-1:0]    i_pitch_lag,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [psc_pkg::IDX_W-1:0]           o_out_source_index,
    output logic                                o_out_track_active,
    output logic                                o_is_speech
);
    import psc_pkg::*;

    localparam int ADDR_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam logic [SRC_CNT_W-1:0] SRC_CNT = SRC_CNT_W'(NUM_SOURCES);

    t_cfg   cfg;

    // memory ports
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_state            rd_st;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_state            n_state;

    // handshake
    logic in_acc;
    logic out_free;
    logic s2_adv;
    logic s2_ready;
    logic s1_adv;
    logic s1_ready;
    logic hazard;
    logic fwd_hit;
    logic [IDX_W-1:0] s1_next_idx;

    // stage 1: state read
    logic                    r_s1_vld;
    logic [IDX_W-1:0]        r_s1_idx;
    logic                    r_s1_act;
    logic                    r_s1_inr;
    logic signed [LAG_W-1:0] r_s1_lag;
    logic                    r_s1_fwd;
    t_state                  r_s1_fwd_st;

    t_state                  s1_st;
    logic signed [LAG_W:0]   d_full;
    logic signed [LAG_W-1:0] d_sat;
    logic signed [LAG_W:0]   ch_diff;
    logic [GAIN_W-1:0]       ch_gain;
    logic [GAIN_W-1:0]       ra_gain;
    logic signed [50:0]      p_ch;
    logic [33:0]             p_up;
    logic [33:0]             p_dn;
    logic                    now_small;
    logic                    prev_small;
    logic                    lag_ok;
    logic                    s1_we;

    // stage 2: update
    logic                    r_s2_vld;
    logic [IDX_W-1:0]        r_s2_idx;
    logic                    r_s2_act;
    logic                    r_s2_inr;
    logic                    r_s2_we;
    logic                    r_s2_latched;
    logic signed [LAG_W-1:0] r_s2_lag;
    logic signed [LAG_W-1:0] r_s2_d;
    logic signed [LAG_W-1:0] r_s2_sm;
    logic                    r_s2_smooth;
    logic                    r_s2_now_small;
    logic                    r_s2_lag_ok;
    logic signed [50:0]      r_s2_p_ch;
    logic [33:0]             r_s2_p_up;
    logic [33:0]             r_s2_p_dn;
    logic [GAIN_W-1:0]       r_s2_ratio;

    logic [51:0]             ch_sum;
    logic [35:0]             ch_q;
    logic signed [LAG_W-1:0] phi;
    logic                    voiced;
    logic [33:0]             ra_sum;
    logic [17:0]             ra_q;
    logic [GAIN_W-1:0]       ra_new;
    logic                    speech_new;

    // result register
    logic             r_out_vld;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_act;
    logic             r_out_speech;

    psc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    psc_state_ram #(
        .DEPTH  (NUM_SOURCES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (n_state),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_st)
    );

    // Pipeline flow: stall stage 1 while stage 2 still owes a write to the same source
    assign out_free    = !r_out_vld || i_out_ready;
    assign s2_adv      = r_s2_vld && out_free;
    assign s2_ready    = !r_s2_vld || out_free;
    assign hazard      = r_s2_vld && r_s2_we && (r_s2_idx == r_s1_idx);
    assign s1_adv      = r_s1_vld && s2_ready && !hazard;
    assign s1_ready    = !r_s1_vld || s1_adv;
    assign o_in_ready  = s1_ready;
    assign in_acc      = i_in_valid && s1_ready;

    // Issue the state read on accept, only for a source that exists
    assign rd_en   = in_acc && ({{(SRC_CNT_W-IDX_W){1'b0}}, i_source_index} < SRC_CNT);
    assign rd_addr = ADDR_W'(i_source_index);

    // Write back from stage 2 when it moves on
    assign wr_en   = s2_adv && r_s2_we;
    assign wr_addr = ADDR_W'(r_s2_idx);

    // Forward a write-back to the item that sits in stage 1 next cycle
    assign s1_next_idx = in_acc ? i_source_index : r_s1_idx;
    assign fwd_hit     = wr_en && (r_s2_idx == s1_next_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_fwd <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (in_acc) begin
                r_s1_fwd <= fwd_hit;
            end else if (fwd_hit) begin
                r_s1_fwd <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idx <= i_source_index;
            r_s1_act <= i_track_active;
            r_s1_inr <= ({{(SRC_CNT_W-IDX_W){1'b0}}, i_source_index} < SRC_CNT);
            r_s1_lag <= i_pitch_lag;
        end
        if (fwd_hit) begin
            r_s1_fwd_st <= n_state;
        end
    end

    // Stage 1: lag change, smallness tests and the smoothing products
    assign s1_st   = r_s1_fwd ? r_s1_fwd_st : rd_st;
    assign d_full  = {r_s1_lag[LAG_W-1], r_s1_lag}
                   - {s1_st.last_lag[LAG_W-1], s1_st.last_lag};

    always_comb begin
        if (d_full[LAG_W] != d_full[LAG_W-1]) begin
            d_sat = d_full[LAG_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            d_sat = d_full[LAG_W-1:0];
        end
    end

    assign now_small  = mag32(d_sat) < {1'b0, cfg.change_limit};
    assign prev_small = mag32(s1_st.last_change) < {1'b0, cfg.change_limit};
    assign lag_ok     = (r_s1_lag >= $signed({1'b0, cfg.lag_min}))
                     && (r_s1_lag <= $signed({1'b0, cfg.lag_max}));

    // (1-a)*s + a*d is s*1.0 + a*(d-s)
    assign ch_gain = clamp_gain(cfg.change_gain);
    assign ch_diff = {d_sat[LAG_W-1], d_sat}
                   - {s1_st.smoothed_change[LAG_W-1], s1_st.smoothed_change};
    assign p_ch    = $signed({1'b0, ch_gain}) * ch_diff;

    // Ratio step: both outcomes of the voiced mark
    assign ra_gain = clamp_gain(cfg.ratio_gain);
    assign p_up    = ra_gain * (Q16_ONE - s1_st.voicing_ratio);
    assign p_dn    = ra_gain * s1_st.voicing_ratio;

    assign s1_we   = r_s1_inr && (!r_s1_act || !s1_st.speech_latched);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s2_vld <= 1'b1;
        end else if (s2_adv) begin
            r_s2_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_idx       <= r_s1_idx;
            r_s2_act       <= r_s1_act;
            r_s2_inr       <= r_s1_inr;
            r_s2_we        <= s1_we;
            r_s2_latched   <= s1_st.speech_latched;
            r_s2_lag       <= r_s1_lag;
            r_s2_d         <= d_sat;
            r_s2_sm        <= s1_st.smoothed_change;
            r_s2_smooth    <= now_small && prev_small;
            r_s2_now_small <= now_small;
            r_s2_lag_ok    <= lag_ok;
            r_s2_p_ch      <= p_ch;
            r_s2_p_up      <= p_up;
            r_s2_p_dn      <= p_dn;
            r_s2_ratio     <= s1_st.voicing_ratio;
        end
    end

    // Stage 2: round and saturate the smoothed change
    assign ch_sum = {{4{r_s2_sm[LAG_W-1]}}, r_s2_sm, 16'h0000}
                  + {r_s2_p_ch[50], r_s2_p_ch}
                  + {36'd0, HALF_LSB};
    assign ch_q   = ch_sum[51:16];

    always_comb begin
        if (r_s2_smooth) begin
            if (ch_q[35:31] == 5'b00000 || ch_q[35:31] == 5'b11111) begin
                phi = ch_q[31:0];
            end else begin
                phi = ch_q[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        end else if (r_s2_now_small) begin
            phi = r_s2_d;
        end else begin
            phi = '0;
        end
    end

    // Voiced mark, ratio update and speech decision
    assign voiced = r_s2_lag_ok && (mag32(phi) > {1'b0, cfg.change_min});
    assign ra_sum = voiced
                  ? ({1'b0, r_s2_ratio, 16'h0000} + r_s2_p_up + {18'd0, HALF_LSB})
                  : ({1'b0, r_s2_ratio, 16'h0000} - r_s2_p_dn + {18'd0, HALF_LSB});
    assign ra_q   = ra_sum[33:16];
    assign ra_new = (ra_q > {1'b0, Q16_ONE}) ? Q16_ONE : ra_q[GAIN_W-1:0];
    assign speech_new = ra_new > cfg.ratio_threshold;

    // New state; an ended track clears it
    always_comb begin
        if (r_s2_act) begin
            n_state.last_lag        = r_s2_lag;
            n_state.last_change     = r_s2_d;
            n_state.smoothed_change = phi;
            n_state.voicing_ratio   = ra_new;
            n_state.speech_latched  = speech_new;
        end else begin
            n_state = '0;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out_idx    <= r_s2_idx;
            r_out_act    <= r_s2_inr && r_s2_act;
            r_out_speech <= r_s2_inr && r_s2_act && (r_s2_latched || speech_new);
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_out_source_index = r_out_idx;
    assign o_out_track_active = r_out_act;
    assign o_is_speech        = r_out_speech;

endmodule

`default_nettype wire

// File: tb/sv/tb_pitch_speech_classifier.sv
// Self-checking testbench for the pitch speech classifier.
// Drives items over valid/ready, programs the APB registers between phases and checks
// every result against a built-in predictor or a typed directed row. Depends on psc_pkg and pitch_speech_classifier.
module tb_pitch_speech_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam int SRC_COUNT      = NUM_SOURCES_DEF;
    localparam int LATENCY        = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 128;
    localparam int LONG_HOLD      = 60;
    localparam int DIR_N          = 23;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             active;
        logic             speech;
    } t_verdict;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             act;
        logic [LAG_W-1:0] lag;
        logic             typed;
        logic             exp_active;
        logic             exp_speech;
    } t_stim_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [IDX_W-1:0]        i_source_index;
    logic                    i_track_active;
    logic signed [LAG_W-1:0] i_pitch_lag;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [IDX_W-1:0]        o_out_source_index;
    logic                    o_out_track_active;
    logic                    o_is_speech;

    // Predictor copy of the registers and per-source state
    t_cfg                    cfg_shadow;
    logic signed [LAG_W-1:0] src_last_lag      [SRC_COUNT];
    logic signed [LAG_W-1:0] src_last_change   [SRC_COUNT];
    logic signed [LAG_W-1:0] src_smooth_change [SRC_COUNT];
    logic [GAIN_W-1:0]       src_ratio         [SRC_COUNT];
    logic                    src_speech        [SRC_COUNT];

    t_verdict speech_verdict_q[$];
    int       verdict_errors  = 0;
    int       items_sent      = 0;
    int       results_seen    = 0;
    int       idle_cycles     = 0;
    bit       in_idle_on      = 1'b1;
    bit       out_idle_on     = 1'b1;

    // Directed items; typed rows carry their result, the rest go through the predictor
    t_stim_row dir_rows [DIR_N] = '{
        '{2'd0, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 1'b0},   // inactive, cleared
        '{2'd3, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
        '{2'd1, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0},   // huge jump, no voicing
        '{2'd1, 1'b1, 32'h8000_0000, 1'b1, 1'b1, 1'b0},   // change saturates low
        '{2'd2, 1'b1, 32'h0000_0100, 1'b0, 1'b0, 1'b0},   // steady climb toward speech
        '{2'd2, 1'b1, 32'h0000_0200, 1'b0, 1'b0, 1'b0},
        '{2'd0, 1'b1, 32'h0001_0000, 1'b0, 1'b0, 1'b0},   // change equal to the limit
        '{2'd2, 1'b1, 32'h0000_0300, 1'b0, 1'b0, 1'b0},
        '{2'd2, 1'b1, 32'h0000_0400, 1'b0, 1'b0, 1'b0},
        '{2'd0, 1'b1, 32'h0001_8000, 1'b0, 1'b0, 1'b0},   // small after large
        '{2'd2, 1'b1, 32'h0000_0500, 1'b0, 1'b0, 1'b0},
        '{2'd2, 1'b1, 32'h0000_0600, 1'b0, 1'b0, 1'b0},
        '{2'd0, 1'b1, 32'h0001_8001, 1'b0, 1'b0, 1'b0},
        '{2'd2, 1'b1, 32'h0000_0700, 1'b0, 1'b0, 1'b0},
        '{2'd2, 1'b1, 32'h0000_0800, 1'b0, 1'b0, 1'b0},
        '{2'd2, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},   // latched speech holds
        '{2'd2, 1'b0, 32'h0000_0800, 1'b1, 1'b0, 1'b0},   // track ends, speech drops
        '{2'd2, 1'b1, 32'h0000_0100, 1'b0, 1'b0, 1'b0},
        '{2'd3, 1'b1, 32'hFFFF_FF00, 1'b0, 1'b0, 1'b0},   // negative lag
        '{2'd3, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
        '{2'd1, 1'b0, 32'h1234_5678, 1'b1, 1'b0, 1'b0},
        '{2'd1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
        '{2'd0, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b0}
    };

    pitch_speech_classifier #(
        .NUM_SOURCES (SRC_COUNT)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_source_index     (i_source_index),
        .i_track_active     (i_track_active),
        .i_pitch_lag        (i_pitch_lag),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_source_index (o_out_source_index),
        .o_out_track_active (o_out_track_active),
        .o_is_speech        (o_is_speech)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Classify one item and advance the predicted state of its source
    function automatic t_verdict classify_pitch(input logic [IDX_W-1:0] idx, input logic act,
                                                input logic signed [LAG_W-1:0] lag);
        t_verdict v;
        longint   d;
        longint   phi;
        longint   a;
        longint   g;
        longint   r;
        logic     small_now;
        logic     small_prev;
        logic     voiced;
        v.idx    = idx;
        v.active = 1'b0;
        v.speech = 1'b0;
        if (int'(idx) >= SRC_COUNT) return v;
        // inactive track wipes the source
        if (!act) begin
            src_last_lag[idx]      = '0;
            src_last_change[idx]   = '0;
            src_smooth_change[idx] = '0;
            src_ratio[idx]         = '0;
            src_speech[idx]        = 1'b0;
            return v;
        end
        if (!src_speech[idx]) begin
            d          = clip32(longint'(lag) - longint'(src_last_lag[idx]));
            small_now  = magnitude(d) < longint'(cfg_shadow.change_limit);
            small_prev = magnitude(longint'(src_last_change[idx]))
                         < longint'(cfg_shadow.change_limit);
            // smooth while continuous, restart on a jump
            if (small_now && small_prev) begin
                a   = (cfg_shadow.change_gain > Q16_ONE) ? 65536
                                                         : longint'(cfg_shadow.change_gain);
                phi = clip32(((65536 - a) * longint'(src_smooth_change[idx]) + a * d + 32768)
                             >>> 16);
            end else if (small_now) begin
                phi = d;
            end else begin
                phi = 0;
            end
            voiced = (longint'(lag) >= longint'(cfg_shadow.lag_min)) &&
                     (longint'(lag) <= longint'(cfg_shadow.lag_max)) &&
                     (magnitude(phi) > longint'(cfg_shadow.change_min));
            // fold the voiced mark into the ratio
            g = (cfg_shadow.ratio_gain > Q16_ONE) ? 65536 : longint'(cfg_shadow.ratio_gain);
            r = (65536 - g) * longint'(src_ratio[idx]) + (voiced ? g * 65536 : 0);
            r = (r + 32768) >>> 16;
            if (r > 65536) r = 65536;
            src_ratio[idx]         = r[GAIN_W-1:0];
            src_speech[idx]        = r > longint'(cfg_shadow.ratio_threshold);
            src_last_lag[idx]      = lag;
            src_last_change[idx]   = d[LAG_W-1:0];
            src_smooth_change[idx] = phi[LAG_W-1:0];
        end
        v.active = 1'b1;
        v.speech = src_speech[idx];
        return v;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic offer_item(input logic [IDX_W-1:0] idx, input logic act,
                              input logic [LAG_W-1:0] lag);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_source_index <= idx;
        i_track_active <= act;
        i_pitch_lag    <= lag;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (items_sent % 48 == 0) in_idle_on = ($urandom_range(0, 3) != 0);
    endtask

    // Stop offering and wait until every result is back and the pipe is empty
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (speech_verdict_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase, then back to idle
    task automatic write_reg(input t_reg_idx r, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (r)
            REG_LAG_MIN:         cfg_shadow.lag_min         = value[LIM_W-1:0];
            REG_LAG_MAX:         cfg_shadow.lag_max         = value[LIM_W-1:0];
            REG_CHANGE_LIMIT:    cfg_shadow.change_limit    = value[LIM_W-1:0];
            REG_CHANGE_GAIN:     cfg_shadow.change_gain     = value[GAIN_W-1:0];
            REG_RATIO_GAIN:      cfg_shadow.ratio_gain      = value[GAIN_W-1:0];
            REG_CHANGE_MIN:      cfg_shadow.change_min      = value[LIM_W-1:0];
            REG_RATIO_THRESHOLD: cfg_shadow.ratio_threshold = value[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // Program one register setting per phase: defaults, both extremes, then random
    task automatic apply_setting(input int p);
        logic [PDATA_W-1:0] lmin;
        logic [PDATA_W-1:0] lmax;
        logic [PDATA_W-1:0] clim;
        logic [PDATA_W-1:0] cg;
        logic [PDATA_W-1:0] rg;
        logic [PDATA_W-1:0] cmin;
        logic [PDATA_W-1:0] thr;
        case (p)
            0: begin
                lmin = 32'(CFG_RESET.lag_min);
                lmax = 32'(CFG_RESET.lag_max);
                clim = 32'(CFG_RESET.change_limit);
                cg   = 32'(CFG_RESET.change_gain);
                rg   = 32'(CFG_RESET.ratio_gain);
                cmin = 32'(CFG_RESET.change_min);
                thr  = 32'(CFG_RESET.ratio_threshold);
            end
            1: begin
                lmin = 32'h7FFF_FFFF;
                lmax = 32'h7FFF_FFFF;
                clim = 32'h7FFF_FFFF;
                cg   = 32'h0001_FFFF;
                rg   = 32'h0001_FFFF;
                cmin = 32'h7FFF_FFFF;
                thr  = 32'h0001_FFFF;
            end
            2: begin
                lmin = '0;
                lmax = '0;
                clim = '0;
                cg   = '0;
                rg   = '0;
                cmin = '0;
                thr  = '0;
            end
            3: begin
                // gains above 1.0, zero threshold: speech comes fast
                lmin = '0;
                lmax = 32'h7FFF_FFFF;
                clim = $urandom_range(32'h100, 32'h8_0000);
                cg   = $urandom_range(32'h1_0001, 32'h1_FFFF);
                rg   = $urandom_range(32'h1_0001, 32'h1_FFFF);
                cmin = '0;
                thr  = '0;
            end
            default: begin
                lmin = $urandom_range(0, 32'h0100_0000);
                lmax = lmin + $urandom_range(0, 32'h0400_0000);
                clim = $urandom_range(32'h100, 32'h8_0000);
                cg   = ($urandom_range(0, 7) == 0) ? $urandom_range(32'h1_0001, 32'h1_FFFF)
                                                   : $urandom_range(0, 32'h1_0000);
                rg   = ($urandom_range(0, 7) == 0) ? $urandom_range(32'h1_0001, 32'h1_FFFF)
                                                   : $urandom_range(1000, 32'h1_0000);
                cmin = $urandom_range(0, clim / 8);
                thr  = ($urandom_range(0, 7) == 0) ? $urandom_range(32'h1_0001, 32'h1_FFFF)
                                                   : $urandom_range(0, 32'h1_0000);
            end
        endcase
        write_reg(REG_LAG_MIN, lmin);
        write_reg(REG_LAG_MAX, lmax);
        write_reg(REG_CHANGE_LIMIT, clim);
        write_reg(REG_CHANGE_GAIN, cg);
        write_reg(REG_RATIO_GAIN, rg);
        write_reg(REG_CHANGE_MIN, cmin);
        write_reg(REG_RATIO_THRESHOLD, thr);
    endtask

    // Mostly continuous pitch tracks per source, with jumps, extremes and track ends
    task automatic make_item(output logic [IDX_W-1:0] idx, output logic act,
                             output logic [LAG_W-1:0] lag);
        int     sel;
        longint lo;
        longint hi;
        longint step;
        longint delta;
        idx = IDX_W'($urandom_range(0, SRC_COUNT - 1));
        sel = $urandom_range(0, 99);
        act = 1'b1;
        lag = $urandom;
        if (sel < 6) begin
            act = 1'b0;
        end else if (sel < 14) begin
            // keep the fully random lag
        end else if (sel < 20) begin
            case ($urandom_range(0, 5))
                0: lag = 32'h7FFF_FFFF;
                1: lag = 32'h8000_0000;
                2: lag = 32'h0000_0000;
                3: lag = 32'hFFFF_FFFF;
                4: lag = {1'b0, cfg_shadow.lag_min};
                default: lag = {1'b0, cfg_shadow.lag_max};
            endcase
        end else if (src_last_lag[idx] == 0) begin
            // fresh track: start inside the voiced lag range
            lo = longint'(cfg_shadow.lag_min);
            hi = longint'(cfg_shadow.lag_max);
            if (hi < lo) begin
                lo = hi;
                hi = longint'(cfg_shadow.lag_min);
            end
            lag = 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
        end else begin
            step = longint'(cfg_shadow.change_limit);
            if (step > 64'sd16777216) step = 64'sd16777216;
            if (step == 0) step = 16;
            case ($urandom_range(0, 9))
                0: delta = longint'(cfg_shadow.change_limit);
                1: delta = -longint'(cfg_shadow.change_limit);
                2: delta = longint'(cfg_shadow.change_limit) - 1;
                default: delta = longint'($urandom_range(0, 32'(2 * step))) - step;
            endcase
            lag = 32'(longint'(src_last_lag[idx]) + delta);
        end
    endtask

    // Stimulus: reset, directed rows, then random phases under changing settings
    initial begin : stimulus
        t_verdict         v;
        logic [IDX_W-1:0] idx;
        logic             act;
        logic [LAG_W-1:0] lag;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_source_index = '0;
        i_track_active = 1'b0;
        i_pitch_lag    = '0;
        i_rst_n        = 1'b0;
        cfg_shadow     = CFG_RESET;
        for (int s = 0; s < SRC_COUNT; s++) begin
            src_last_lag[s]      = '0;
            src_last_change[s]   = '0;
            src_smooth_change[s] = '0;
            src_ratio[s]         = '0;
            src_speech[s]        = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed rows
        for (int k = 0; k < DIR_N; k++) begin
            offer_item(dir_rows[k].idx, dir_rows[k].act, dir_rows[k].lag);
            v = classify_pitch(dir_rows[k].idx, dir_rows[k].act, dir_rows[k].lag);
            if (dir_rows[k].typed) begin
                v.idx    = dir_rows[k].idx;
                v.active = dir_rows[k].exp_active;
                v.speech = dir_rows[k].exp_speech;
            end
            speech_verdict_q.push_back(v);
        end

        // random phases, reprogrammed only once the pipe is empty
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_pipe();
            apply_setting(p);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                make_item(idx, act, lag);
                offer_item(idx, act, lag);
                speech_verdict_q.push_back(classify_pitch(idx, act, lag));
            end
        end

        drain_pipe();
        verdict_errors += speech_verdict_q.size();
        if (verdict_errors == 0) begin
            $display("tb_pitch_speech_classifier: done, clean");
        end else begin
            $display("tb_pitch_speech_classifier: done, errors");
        end
        $finish;
    end

    // Result sink: random stalls, one long hold-off, compare against the oldest prediction
    initial begin : result_sink
        int       w;
        bit       long_hold_done;
        t_verdict got;
        t_verdict want;
        long_hold_done = 1'b0;
        i_out_ready    = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            // hold off in the middle of a phase so the sender keeps offering
            if (!long_hold_done && results_seen >= 300) begin
                w              = LONG_HOLD;
                long_hold_done = 1'b1;
            end else begin
                w = out_idle_on ? $urandom_range(0, 4) : 0;
            end
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            results_seen++;
            if (results_seen % 64 == 0) out_idle_on = ($urandom_range(0, 2) != 0);
            got = '{o_out_source_index, o_out_track_active, o_is_speech};
            if (speech_verdict_q.size() == 0) begin
                verdict_errors++;
                if (verdict_errors <= 10)
                    $display("%0t: result with nothing pending: source %0d active %0b speech %0b",
                             $realtime, got.idx, got.active, got.speech);
            end else begin
                want = speech_verdict_q.pop_front();
                if (got.idx != want.idx || got.active != want.active ||
                    got.speech != want.speech) begin
                    verdict_errors++;
                    if (verdict_errors <= 10)
                        $display({"%0t: mismatch: expected source %0d active %0b speech %0b,",
                                  " got source %0d active %0b speech %0b"},
                                 $realtime, want.idx, want.active, want.speech,
                                 got.idx, got.active, got.speech);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_pitch_speech_classifier: done, errors");
            $finish;
        end
    end

endmodule
